>>> src/ccarb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the crossbar channel arbiter.
// No dependencies; imported by crossbar_channel_arbiter, ccarb_grant and ccarb_rsp.
package ccarb_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int NUM_PORTS_DEF   = 16;
   localparam int MAX_RESULTS     = 16;
   localparam int RES_CNT_BITS    = $clog2(MAX_RESULTS + 1);

   localparam int PORT_BITS  = 4;
   localparam int PORT_SLOTS = 16;
   localparam int TIME_BITS  = 32;
   localparam int DELAY_BITS = 8;
   localparam int MASK_BITS  = 16;

   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [DELAY_BITS-1:0] ARB_DELAY_RST   = 8'd1;
   localparam logic [DELAY_BITS-1:0] XFER_DELAY_RST  = 8'd1;
   localparam logic [MASK_BITS-1:0]  MASTER_MASK_RST = 16'h00FF;

   typedef enum logic [1:0] {
      KIND_ENQ   = 2'd0,
      KIND_BLOCK = 2'd1,
      KIND_TICK  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      OUT_GRANT  = 2'd0,
      OUT_FULL   = 2'd1,
      OUT_NO_DST = 2'd2
   } outcome_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ARB_DELAY   = 2'd0,
      CSR_XFER_DELAY  = 2'd1,
      CSR_MASTER_MASK = 2'd2
   } csr_index_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_WALK = 1'b1
   } state_type;

   typedef struct packed {
      logic [PORT_BITS-1:0] src;
      logic [PORT_BITS-1:0] dst;
      logic [TIME_BITS-1:0] arrive;
   } entry_type;

   typedef struct packed {
      logic grant;
      logic via_bus;
   } grant_type;

   typedef struct packed {
      logic                 drop;
      logic                 grant;
      logic                 flush;
      outcome_type          outcome;
      logic [PORT_BITS-1:0] src;
      logic [PORT_BITS-1:0] dst;
      logic                 via_bus;
   } rsp_ctl_type;

   typedef struct packed {
      logic out_free;
      logic pend_valid;
   } rsp_stat_type;

endpackage

>>> src/crossbar_channel_arbiter.sv
`timescale 1ns / 1ps
// Oldest-first crossbar arbiter: request queue RAM, walk sequencer, config registers.
// Depends on ccarb_pkg, ccarb_ram, ccarb_grant, ccarb_rsp.
//
//   channel  prefix  direction  carries
//   request  req_    in         enqueue, blocked mark or tick item
//   result   rsp_    out        grant or drop report, last flag
//   config   csr_    in         register writes, index 0..2
//
// Enqueue, blocked and unused items are taken in the idle state.
// In a tick the walk reads one queue entry per cycle, unless a grant stalls, through
// the single read port of the queue RAM and writes survivors back compacted.
// A grant waits while the held grant cannot move into a full output register.
// Reset clears control state only; the queue RAM needs no clearing pass.
module crossbar_channel_arbiter #(
   parameter int QUEUE_DEPTH = ccarb_pkg::QUEUE_DEPTH_DEF,
   parameter int NUM_PORTS   = ccarb_pkg::NUM_PORTS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [ccarb_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [ccarb_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [1:0]                             req_kind,
   input  logic [ccarb_pkg::PORT_BITS-1:0]        req_src_port,
   input  logic [ccarb_pkg::PORT_BITS-1:0]        req_dst_port,
   input  logic                                   req_dst_valid,
   input  logic                                   req_blocked_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [1:0]                             rsp_outcome,
   output logic [ccarb_pkg::PORT_BITS-1:0]        rsp_granted_src,
   output logic [ccarb_pkg::PORT_BITS-1:0]        rsp_granted_dst,
   output logic                                   rsp_via_bus,
   output logic                                   rsp_last
);
   import ccarb_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int PW = $clog2(NUM_PORTS);
   localparam logic [CW-1:0]        DEPTH_CNT  = CW'(QUEUE_DEPTH);
   localparam logic [PORT_BITS:0]   PORT_LIMIT = (PORT_BITS + 1)'(NUM_PORTS);

   logic [DELAY_BITS-1:0]   arb_delay_ff, arb_delay_in;
   logic [DELAY_BITS-1:0]   xfer_delay_ff, xfer_delay_in;
   logic [MASK_BITS-1:0]    master_mask_ff, master_mask_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [TIME_BITS-1:0]    cycle_ff, cycle_in;
   logic [TIME_BITS-1:0]    bus_free_ff, bus_free_in;
   logic [NUM_PORTS-1:0]    blocked_ff, blocked_in;
   state_type               state_ff, state_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic [CW-1:0]           wr_ff, wr_in;
   logic [RES_CNT_BITS-1:0] n_ff, n_in;
   logic [PORT_SLOTS-1:0]   used_ff, used_in;
   logic                    bus_busy_ff, bus_busy_in;

   logic                    accept, dst_ok, full, at_end, stall, advance, done;
   logic [CW-1:0]           idx_next;
   logic [TIME_BITS-1:0]    tick_cycle;
   logic                    ram_we;
   logic [AW-1:0]           ram_waddr, ram_raddr;
   entry_type               ram_wdata, rd_entry;
   grant_type               gnt;
   rsp_ctl_type             rsp_ctl;
   rsp_stat_type            rsp_stat;

   ccarb_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (rd_entry)
   );

   ccarb_grant #(
      .NUM_PORTS (NUM_PORTS)
   ) u_grant (
      .entry       (rd_entry),
      .cycle       (cycle_ff),
      .arb_delay   (arb_delay_ff),
      .master_mask (master_mask_ff),
      .blocked     (blocked_ff),
      .used        (used_ff),
      .bus_busy    (bus_busy_ff),
      .grant_cnt   (n_ff),
      .result      (gnt)
   );

   ccarb_rsp u_rsp (
      .clock           (clock),
      .reset           (reset),
      .ctl             (rsp_ctl),
      .stat            (rsp_stat),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_outcome     (rsp_outcome),
      .rsp_granted_src (rsp_granted_src),
      .rsp_granted_dst (rsp_granted_dst),
      .rsp_via_bus     (rsp_via_bus),
      .rsp_last        (rsp_last)
   );

   assign dst_ok     = req_dst_valid && ({1'b0, req_dst_port} < PORT_LIMIT);
   assign full       = count_ff == DEPTH_CNT;
   assign idx_next   = idx_ff + 1'b1;
   assign tick_cycle = cycle_ff + 1'b1;

   // walk control and queue RAM access
   always_comb begin
      req_ready = 1'b0;
      accept    = 1'b0;
      at_end    = 1'b0;
      stall     = 1'b0;
      advance   = 1'b0;
      done      = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = wr_ff[AW-1:0];
      ram_wdata = rd_entry;
      ram_raddr = '0;
      rsp_ctl   = '0;
      rsp_ctl.outcome = OUT_GRANT;

      case (state_ff)
         ST_IDLE: begin
            req_ready = rsp_stat.out_free;
            accept    = req_valid && req_ready;
            if (accept && req_kind == KIND_ENQ) begin
               if (!dst_ok) begin
                  rsp_ctl.drop    = 1'b1;
                  rsp_ctl.outcome = OUT_NO_DST;
                  rsp_ctl.src     = req_src_port;
               end else if (full) begin
                  rsp_ctl.drop    = 1'b1;
                  rsp_ctl.outcome = OUT_FULL;
                  rsp_ctl.src     = req_src_port;
               end else begin
                  ram_we           = 1'b1;
                  ram_waddr        = count_ff[AW-1:0];
                  ram_wdata.src    = req_src_port;
                  ram_wdata.dst    = req_dst_port;
                  ram_wdata.arrive = cycle_ff;
               end
            end
         end
         ST_WALK: begin
            at_end  = idx_ff == count_ff;
            stall   = !at_end && gnt.grant && rsp_stat.pend_valid && !rsp_stat.out_free;
            advance = !at_end && !stall;
            done    = at_end && (!rsp_stat.pend_valid || rsp_stat.out_free);
            ram_raddr = advance ? idx_next[AW-1:0] : idx_ff[AW-1:0];
            ram_we    = advance && !gnt.grant;
            if (advance && gnt.grant) begin
               rsp_ctl.grant   = 1'b1;
               rsp_ctl.src     = rd_entry.src;
               rsp_ctl.dst     = rd_entry.dst;
               rsp_ctl.via_bus = gnt.via_bus;
            end
            rsp_ctl.flush = at_end && rsp_stat.pend_valid && rsp_stat.out_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_kind == KIND_TICK) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      arb_delay_in   = arb_delay_ff;
      xfer_delay_in  = xfer_delay_ff;
      master_mask_in = master_mask_ff;
      count_in       = count_ff;
      cycle_in       = cycle_ff;
      bus_free_in    = bus_free_ff;
      blocked_in     = blocked_ff;
      idx_in         = idx_ff;
      wr_in          = wr_ff;
      n_in           = n_ff;
      used_in        = used_ff;
      bus_busy_in    = bus_busy_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_ARB_DELAY:   arb_delay_in   = csr_wdata[DELAY_BITS-1:0];
            CSR_XFER_DELAY:  xfer_delay_in  = csr_wdata[DELAY_BITS-1:0];
            CSR_MASTER_MASK: master_mask_in = csr_wdata[MASK_BITS-1:0];
            default: begin
            end
         endcase
      end

      if (accept) begin
         case (req_kind)
            KIND_ENQ: begin
               if (dst_ok && !full) begin
                  count_in = count_ff + 1'b1;
               end
            end
            KIND_BLOCK: begin
               if ({1'b0, req_dst_port} < PORT_LIMIT) begin
                  blocked_in[req_dst_port[PW-1:0]] = req_blocked_value;
               end
            end
            KIND_TICK: begin
               cycle_in    = tick_cycle;
               bus_busy_in = tick_cycle <= bus_free_ff;
               idx_in      = '0;
               wr_in       = '0;
               n_in        = '0;
               used_in     = '0;
            end
            default: begin
            end
         endcase
      end

      if (advance) begin
         idx_in = idx_next;
         if (gnt.grant) begin
            n_in = n_ff + 1'b1;
            if (gnt.via_bus) begin
               bus_busy_in = 1'b1;
               bus_free_in = cycle_ff + {{(TIME_BITS-DELAY_BITS){1'b0}}, xfer_delay_ff};
            end else begin
               used_in[rd_entry.src] = 1'b1;
               used_in[rd_entry.dst] = 1'b1;
            end
         end else begin
            wr_in = wr_ff + 1'b1;
         end
      end

      if (done) begin
         count_in = wr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arb_delay_ff   <= ARB_DELAY_RST;
         xfer_delay_ff  <= XFER_DELAY_RST;
         master_mask_ff <= MASTER_MASK_RST;
         count_ff       <= '0;
         cycle_ff       <= '0;
         bus_free_ff    <= '0;
         blocked_ff     <= '0;
         state_ff       <= ST_IDLE;
         idx_ff         <= '0;
         wr_ff          <= '0;
         n_ff           <= '0;
         used_ff        <= '0;
         bus_busy_ff    <= 1'b0;
      end else begin
         arb_delay_ff   <= arb_delay_in;
         xfer_delay_ff  <= xfer_delay_in;
         master_mask_ff <= master_mask_in;
         count_ff       <= count_in;
         cycle_ff       <= cycle_in;
         bus_free_ff    <= bus_free_in;
         blocked_ff     <= blocked_in;
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         wr_ff          <= wr_in;
         n_ff           <= n_in;
         used_ff        <= used_in;
         bus_busy_ff    <= bus_busy_in;
      end
   end

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue count beyond depth");

   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> wr_ff <= idx_ff && idx_ff <= count_ff)
      else $error("write-back index passed read index");

   a_idle_no_held: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !rsp_stat.pend_valid)
      else $error("held grant left behind after walk");

   a_grant_limit: assert property (@(posedge clock) disable iff (reset)
      n_ff <= RES_CNT_BITS'(MAX_RESULTS))
      else $error("too many grants in one tick");

   a_tick_cycle: assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == KIND_TICK |=> cycle_ff == $past(cycle_ff) + 1'b1)
      else $error("cycle counter did not advance on tick");
`endif

endmodule

>>> src/ccarb_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ccarb_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/ccarb_grant.sv
`timescale 1ns / 1ps
// Grant decision for one queued request during an arbitration walk.
// Depends on ccarb_pkg.
module ccarb_grant #(
   parameter int NUM_PORTS = ccarb_pkg::NUM_PORTS_DEF
) (
   input  ccarb_pkg::entry_type                     entry,
   input  logic [ccarb_pkg::TIME_BITS-1:0]          cycle,
   input  logic [ccarb_pkg::DELAY_BITS-1:0]         arb_delay,
   input  logic [ccarb_pkg::MASK_BITS-1:0]          master_mask,
   input  logic [NUM_PORTS-1:0]                     blocked,
   input  logic [ccarb_pkg::PORT_SLOTS-1:0]         used,
   input  logic                                     bus_busy,
   input  logic [ccarb_pkg::RES_CNT_BITS-1:0]       grant_cnt,
   output ccarb_pkg::grant_type                     result
);
   import ccarb_pkg::*;

   localparam int PW = $clog2(NUM_PORTS);

   logic [TIME_BITS-1:0] age;
   logic old_enough, room, dst_master, src_master, dst_blocked, bus_req, chan_free;

   always_comb begin
      age         = cycle - entry.arrive;
      old_enough  = age >= {{(TIME_BITS-DELAY_BITS){1'b0}}, arb_delay};
      room        = grant_cnt < RES_CNT_BITS'(MAX_RESULTS);
      dst_master  = master_mask[entry.dst];
      src_master  = master_mask[entry.src];
      dst_blocked = !dst_master && blocked[entry.dst[PW-1:0]];
      bus_req     = dst_master && src_master;
      chan_free   = !used[entry.src] && !used[entry.dst];
      result.via_bus = bus_req;
      result.grant   = room && old_enough && !dst_blocked &&
                       (bus_req ? !bus_busy : chan_free);
   end

endmodule

>>> src/ccarb_rsp.sv
`timescale 1ns / 1ps
// Result stage: one held grant (so the last flag is known) and the output register.
// Depends on ccarb_pkg.
module ccarb_rsp (
   input  logic                                clock,
   input  logic                                reset,
   input  ccarb_pkg::rsp_ctl_type              ctl,
   output ccarb_pkg::rsp_stat_type             stat,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_outcome,
   output logic [ccarb_pkg::PORT_BITS-1:0]     rsp_granted_src,
   output logic [ccarb_pkg::PORT_BITS-1:0]     rsp_granted_dst,
   output logic                                rsp_via_bus,
   output logic                                rsp_last
);
   import ccarb_pkg::*;

   logic                 rsp_valid_ff, rsp_valid_in;
   outcome_type          outcome_ff, outcome_in;
   logic [PORT_BITS-1:0] src_ff, src_in, dst_ff, dst_in;
   logic                 bus_ff, bus_in, last_ff, last_in;

   logic                 pend_valid_ff, pend_valid_in;
   logic [PORT_BITS-1:0] pend_src_ff, pend_src_in, pend_dst_ff, pend_dst_in;
   logic                 pend_bus_ff, pend_bus_in;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      outcome_in    = outcome_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      bus_in        = bus_ff;
      last_in       = last_ff;
      pend_valid_in = pend_valid_ff;
      pend_src_in   = pend_src_ff;
      pend_dst_in   = pend_dst_ff;
      pend_bus_in   = pend_bus_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (ctl.drop) begin
         rsp_valid_in = 1'b1;
         outcome_in   = ctl.outcome;
         src_in       = ctl.src;
         dst_in       = '0;
         bus_in       = 1'b0;
         last_in      = 1'b1;
      end else if ((ctl.grant && pend_valid_ff) || ctl.flush) begin
         rsp_valid_in = 1'b1;
         outcome_in   = OUT_GRANT;
         src_in       = pend_src_ff;
         dst_in       = pend_dst_ff;
         bus_in       = pend_bus_ff;
         last_in      = ctl.flush;
      end

      if (ctl.grant) begin
         pend_valid_in = 1'b1;
         pend_src_in   = ctl.src;
         pend_dst_in   = ctl.dst;
         pend_bus_in   = ctl.via_bus;
      end else if (ctl.flush) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      outcome_ff  <= outcome_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      bus_ff      <= bus_in;
      last_ff     <= last_in;
      pend_src_ff <= pend_src_in;
      pend_dst_ff <= pend_dst_in;
      pend_bus_ff <= pend_bus_in;
   end

   assign stat.out_free   = !rsp_valid_ff || rsp_ready;
   assign stat.pend_valid = pend_valid_ff;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_outcome     = outcome_ff;
   assign rsp_granted_src = src_ff;
   assign rsp_granted_dst = dst_ff;
   assign rsp_via_bus     = bus_ff;
   assign rsp_last        = last_ff;

endmodule
